[hw/rtl/cda_pkg.sv]
// ----------------------------------------------------------------------------
// cda_pkg: shared types, constants and tables of the date shifter
// Status and unit codes, reciprocal constants for division by fixed values,
// and the month tables used by the civil date conversions.
// ----------------------------------------------------------------------------
package cda_pkg;

	// pipeline stages s1..s10; enable bit PIPE_DEPTH+1 loads the result register
	localparam int PIPE_DEPTH = 10;

	typedef logic [PIPE_DEPTH+1:1] stage_en_t;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK     = 2'd0;
	localparam status_t ST_RANGE  = 2'd1;
	localparam status_t ST_UNSUP  = 2'd2;

	typedef logic [2:0] unit_t;
	localparam unit_t UNIT_DAYS   = 3'd0;
	localparam unit_t UNIT_WEEKS  = 3'd1;
	localparam unit_t UNIT_MONTHS = 3'd2;
	localparam unit_t UNIT_YEARS  = 3'd3;

	typedef struct packed {
		logic [16:0]        date;
		logic signed [10:0] count;
		unit_t              unit;
	} item_ctx_t;

	localparam logic [16:0] SERIAL_MIN = 17'd1;
	localparam logic [16:0] SERIAL_MAX = 17'd109574;

	// serial 0 (30 Dec 1899) in days counted from 1 Mar of year 0
	localparam logic [19:0] EPOCH_OFS = 20'd693899;
	// first day of the 400-year eras starting 1 Mar 1600 and 1 Mar 2000
	localparam logic [19:0] ERA4_BASE = 20'd584388;
	localparam logic [19:0] ERA5_BASE = 20'd730485;
	localparam logic [11:0] ERA4_YEAR = 12'd1600;
	localparam logic [11:0] ERA5_YEAR = 12'd2000;

	localparam logic [4:0] FEB_LEAP_LAST  = 5'd29;
	localparam logic [4:0] FEB_PLAIN_LAST = 5'd28;

	// floor(x / c) = (x * ceil(2^sh / c)) >> sh, exact while x * c < 2^sh
	localparam int DIV1460_SH = 29;
	localparam logic [18:0] DIV1460_M = 19'(((64'd1 << DIV1460_SH) + 64'd1459) / 64'd1460);
	localparam int DIV365_SH = 27;
	localparam logic [18:0] DIV365_M = 19'(((64'd1 << DIV365_SH) + 64'd364) / 64'd365);
	localparam int DIV153_SH = 19;
	localparam logic [11:0] DIV153_M = 12'(((64'd1 << DIV153_SH) + 64'd152) / 64'd153);
	localparam int DIV12_SH = 19;
	localparam logic [15:0] DIV12_M = 16'(((64'd1 << DIV12_SH) + 64'd11) / 64'd12);
	localparam int DIV100_SH = 19;
	localparam logic [12:0] DIV100_M = 13'(((64'd1 << DIV100_SH) + 64'd99) / 64'd100);

	// days from 1 Mar to the first of the month, months counted from March = 0
	function automatic logic [8:0] month_offset(input logic [3:0] mp);
		logic [8:0] ofs;
		case (mp)
			4'd0: ofs = 9'd0;
			4'd1: ofs = 9'd31;
			4'd2: ofs = 9'd61;
			4'd3: ofs = 9'd92;
			4'd4: ofs = 9'd122;
			4'd5: ofs = 9'd153;
			4'd6: ofs = 9'd184;
			4'd7: ofs = 9'd214;
			4'd8: ofs = 9'd245;
			4'd9: ofs = 9'd275;
			4'd10: ofs = 9'd306;
			4'd11: ofs = 9'd337;
			default: ofs = 9'd0;
		endcase
		return ofs;
	endfunction

	// last day of a month in a common year
	function automatic logic [4:0] month_last(input logic [3:0] m);
		logic [4:0] last;
		case (m)
			4'd2: last = FEB_PLAIN_LAST;
			4'd4: last = 5'd30;
			4'd6: last = 5'd30;
			4'd9: last = 5'd30;
			4'd11: last = 5'd30;
			default: last = 5'd31;
		endcase
		return last;
	endfunction

endpackage

[hw/rtl/cda_to_civil.sv]
// ----------------------------------------------------------------------------
// cda_to_civil: day serial to civil year, month and day
// Five stages: era split, year-of-era numerator, year of era, day of year,
// month and day. Divisions by fixed values use reciprocal multiplies.
// ----------------------------------------------------------------------------
module cda_to_civil (
	input  logic              clk,
	input  cda_pkg::stage_en_t en,
	input  logic [16:0]       date_s1,
	output logic [11:0]       year_s6,
	output logic [3:0]        month_s6,
	output logic [4:0]        day_s6
);
	import cda_pkg::*;

	logic [19:0] z;
	logic        era5;
	logic [17:0] doe;
	logic [17:0] doe_s2;
	logic        era5_s2;

	logic [36:0] p1460;
	logic [6:0]  q1460;
	logic [2:0]  n_cent;
	logic [17:0] t;
	logic [17:0] t_s3;
	logic [17:0] doe_s3;
	logic        era5_s3;

	logic [36:0] p365;
	logic [8:0]  yoe;
	logic [8:0]  yoe_s4;
	logic [17:0] doe_s4;
	logic        era5_s4;

	logic [1:0]  c100;
	logic [17:0] ydays;
	logic [8:0]  doy;
	logic [8:0]  doy_s5;
	logic [8:0]  yoe_s5;
	logic        era5_s5;

	logic [10:0] x153;
	logic [22:0] p153;
	logic [3:0]  mp;
	logic [3:0]  mon;
	logic [4:0]  day;
	logic [11:0] year;

	// stage 1: pick the era (only 1600 and 2000 are reachable)
	always_comb begin
		z    = {3'b000, date_s1} + EPOCH_OFS;
		era5 = (z >= ERA5_BASE);
		doe  = 18'(z - (era5 ? ERA5_BASE : ERA4_BASE));
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			doe_s2  <= doe;
			era5_s2 <= era5;
		end
	end

	// stage 2: doe - doe/1460 + doe/36524 - doe/146096
	always_comb begin
		p1460  = 37'(doe_s2) * 37'(DIV1460_M);
		q1460  = p1460[DIV1460_SH+6:DIV1460_SH];
		n_cent = 3'(doe_s2 >= 18'd36524) + 3'(doe_s2 >= 18'd73048)
			+ 3'(doe_s2 >= 18'd109572) + 3'(doe_s2 >= 18'd146096);
		t      = doe_s2 - 18'(q1460) + 18'(n_cent) - 18'(doe_s2 == 18'd146096);
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			t_s3    <= t;
			doe_s3  <= doe_s2;
			era5_s3 <= era5_s2;
		end
	end

	// stage 3: year of era
	always_comb begin
		p365 = 37'(t_s3) * 37'(DIV365_M);
		yoe  = p365[DIV365_SH+8:DIV365_SH];
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			yoe_s4  <= yoe;
			doe_s4  <= doe_s3;
			era5_s4 <= era5_s3;
		end
	end

	// stage 4: day of the March-based year
	always_comb begin
		c100  = 2'(yoe_s4 >= 9'd100) + 2'(yoe_s4 >= 9'd200) + 2'(yoe_s4 >= 9'd300);
		ydays = 18'(yoe_s4) * 18'd365 + 18'(yoe_s4[8:2]) - 18'(c100);
		doy   = 9'(doe_s4 - ydays);
	end

	always_ff @(posedge clk) begin
		if (en[5]) begin
			doy_s5  <= doy;
			yoe_s5  <= yoe_s4;
			era5_s5 <= era5_s4;
		end
	end

	// stage 5: month from day of year, Jan/Feb belong to the next civil year
	always_comb begin
		x153 = 11'(doy_s5) * 11'd5 + 11'd2;
		p153 = 23'(x153) * 23'(DIV153_M);
		mp   = p153[DIV153_SH+3:DIV153_SH];
		day  = 5'(doy_s5 - month_offset(mp) + 9'd1);
		mon  = (mp < 4'd10) ? (mp + 4'd3) : (mp - 4'd9);
		year = 12'(yoe_s5) + (era5_s5 ? ERA5_YEAR : ERA4_YEAR) + 12'(mon <= 4'd2);
	end

	always_ff @(posedge clk) begin
		if (en[6]) begin
			year_s6  <= year;
			month_s6 <= mon;
			day_s6   <= day;
		end
	end

endmodule

[hw/rtl/cda_shift.sv]
// ----------------------------------------------------------------------------
// cda_shift: move a civil date by months or years
// Stage 6 forms the month total and the shifted year, stage 7 splits the
// month total back into year and month.
// ----------------------------------------------------------------------------
module cda_shift (
	input  logic               clk,
	input  cda_pkg::stage_en_t en,
	input  cda_pkg::item_ctx_t ctx_s6,
	input  cda_pkg::unit_t     unit_s7,
	input  logic [11:0]        year_s6,
	input  logic [3:0]         month_s6,
	input  logic [4:0]         day_s6,
	output logic [11:0]        year_s8,
	output logic [3:0]         month_s8,
	output logic [4:0]         day_s8
);
	import cda_pkg::*;

	logic [16:0] cnt17;
	logic [16:0] total17;
	logic [11:0] yrs;
	logic [14:0] total_s7;
	logic [11:0] yrs_s7;
	logic [3:0]  month_s7;
	logic [4:0]  day_s7;

	logic [30:0] p12;
	logic [11:0] qt;
	logic [14:0] rem;
	logic [11:0] year_nx;
	logic [3:0]  month_nx;

	// stage 6: totals stay positive over the whole input range
	always_comb begin
		cnt17   = {{6{ctx_s6.count[10]}}, ctx_s6.count};
		total17 = 17'(year_s6) * 17'd12 + 17'(month_s6) - 17'd1 + cnt17;
		yrs     = year_s6 + {ctx_s6.count[10], ctx_s6.count};
	end

	always_ff @(posedge clk) begin
		if (en[7]) begin
			total_s7 <= total17[14:0];
			yrs_s7   <= yrs;
			month_s7 <= month_s6;
			day_s7   <= day_s6;
		end
	end

	// stage 7: total / 12 and total % 12
	always_comb begin
		p12 = 31'(total_s7) * 31'(DIV12_M);
		qt  = p12[DIV12_SH+11:DIV12_SH];
		rem = total_s7 - 15'(qt) * 15'd12;
		if (unit_s7 == UNIT_MONTHS) begin
			year_nx  = qt;
			month_nx = rem[3:0] + 4'd1;
		end else begin
			year_nx  = yrs_s7;
			month_nx = month_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en[8]) begin
			year_s8  <= year_nx;
			month_s8 <= month_nx;
			day_s8   <= day_s7;
		end
	end

endmodule

[hw/rtl/cda_to_serial.sv]
// ----------------------------------------------------------------------------
// cda_to_serial: end-of-month clamp and civil date back to day count
// Stage 8 divides the year by 100, stage 9 clamps the day and forms the day
// count from 1 Mar of year 0 split into a year part and a day-of-year part.
// ----------------------------------------------------------------------------
module cda_to_serial (
	input  logic               clk,
	input  cda_pkg::stage_en_t en,
	input  logic [11:0]        year_s8,
	input  logic [3:0]         month_s8,
	input  logic [4:0]         day_s8,
	output logic [20:0]        base_s10,
	output logic [8:0]         doy_s10
);
	import cda_pkg::*;

	logic [24:0] p100;
	logic [24:0] py100;
	logic [11:0] yy;
	logic [11:0] year_s9;
	logic [3:0]  month_s9;
	logic [4:0]  day_s9;
	logic [5:0]  q100_s9;
	logic [11:0] yy_s9;
	logic [5:0]  qy100_s9;

	logic        leap;
	logic [4:0]  last;
	logic [4:0]  dclamp;
	logic [3:0]  mp;
	logic [8:0]  doy;
	logic [20:0] base;

	// stage 8: Jan and Feb count with the previous March-based year
	always_comb begin
		yy    = (month_s8 <= 4'd2) ? (year_s8 - 12'd1) : year_s8;
		p100  = 25'(year_s8) * 25'(DIV100_M);
		py100 = 25'(yy) * 25'(DIV100_M);
	end

	always_ff @(posedge clk) begin
		if (en[9]) begin
			year_s9  <= year_s8;
			month_s9 <= month_s8;
			day_s9   <= day_s8;
			q100_s9  <= p100[DIV100_SH+5:DIV100_SH];
			yy_s9    <= yy;
			qy100_s9 <= py100[DIV100_SH+5:DIV100_SH];
		end
	end

	// stage 9: a day past the end of the month falls back to its last day;
	// this also turns 29 Feb into 28 Feb for a common target year
	always_comb begin
		leap   = (year_s9[1:0] == 2'b00)
			&& ((year_s9 != 12'(q100_s9) * 12'd100) || (q100_s9[1:0] == 2'b00));
		last   = (month_s9 == 4'd2) ? (leap ? FEB_LEAP_LAST : FEB_PLAIN_LAST)
			: month_last(month_s9);
		dclamp = (day_s9 > last) ? last : day_s9;
		mp     = (month_s9 > 4'd2) ? (month_s9 - 4'd3) : (month_s9 + 4'd9);
		doy    = month_offset(mp) + 9'(dclamp) - 9'd1;
		base   = 21'(yy_s9) * 21'd365 + 21'(yy_s9[11:2]) - 21'(qy100_s9)
			+ 21'(qy100_s9[5:2]);
	end

	always_ff @(posedge clk) begin
		if (en[10]) begin
			base_s10 <= base;
			doy_s10  <= doy;
		end
	end

endmodule

[hw/rtl/calendar_date_add_period.sv]
// ----------------------------------------------------------------------------
// calendar_date_add_period: shift a day serial by days, weeks, months, years
// Top level: input register, item pipeline control, range check and result
// register around the civil date conversion stages.
// ----------------------------------------------------------------------------
// Input channel item_*: date_serial (serial 1 = 31 Dec 1899), signed
// period_count and period_unit (0 days, 1 weeks, 2 months, 3 years).
// Output channel result_*: result_serial and status (0 ok, 1 shifted date
// outside 1..109574, 2 unknown unit); on a nonzero status result_serial is the
// input date. Month shifts clamp the day to the end of the target month.
// Both channels move an item on a clock edge where valid is high and stall
// is low.
// Each item passes through 10 pipeline stages, the last one loading the result
// register. Throughput: one item per cycle while item_stall is low; each stage
// holds one item, with at most one reciprocal multiply on any path between
// registers.
// When result_stall is held, items keep moving into empty stages behind the
// waiting result; item_stall rises only once all stages and the result
// register are full.
// Reset empties every stage and drops result_valid; no items are lost or
// created by stalls on either side.
// ----------------------------------------------------------------------------
module calendar_date_add_period (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  logic [16:0]          date_serial,
	input  logic signed [10:0]   period_count,
	input  logic [2:0]           period_unit,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic [16:0]          result_serial,
	output cda_pkg::status_t     status
);
	import cda_pkg::*;

	stage_en_t             en;
	logic [PIPE_DEPTH:1]   vld_s;
	logic                  result_valid_q;
	logic [16:0]           result_q;
	status_t               status_q;
	item_ctx_t             ctx_s [1:PIPE_DEPTH];
	logic                  out_blocked;

	logic [11:0]           year_s6;
	logic [3:0]            month_s6;
	logic [4:0]            day_s6;
	logic [11:0]           year_s8;
	logic [3:0]            month_s8;
	logic [4:0]            day_s8;
	logic [20:0]           base_s10;
	logic [8:0]            doy_s10;

	logic [21:0]           cnt22;
	logic [21:0]           step;
	logic signed [21:0]    res_d;
	logic signed [21:0]    res_c;
	logic signed [21:0]    res;
	logic [16:0]           result_nx;
	status_t               status_nx;

	// a stage loads when it is empty or every stage after it is moving
	always_comb begin
		out_blocked = result_valid_q && result_stall;
		en[PIPE_DEPTH+1] = !out_blocked;
		for (int i = 1; i <= PIPE_DEPTH; i++) begin
			en[i] = !(((vld_s >> (i - 1)) == ({PIPE_DEPTH{1'b1}} >> (i - 1)))
				&& out_blocked);
		end
	end

	assign item_stall    = !en[1];
	assign result_valid  = result_valid_q;
	assign result_serial = result_q;
	assign status        = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (en[1]) begin
				vld_s[1] <= item_valid;
			end
			for (int i = 2; i <= PIPE_DEPTH; i++) begin
				if (en[i]) begin
					vld_s[i] <= vld_s[i-1];
				end
			end
			if (en[PIPE_DEPTH+1]) begin
				result_valid_q <= vld_s[PIPE_DEPTH];
			end
		end
	end

	// item context rides along with the arithmetic
	always_ff @(posedge clk) begin
		if (en[1]) begin
			ctx_s[1] <= '{date: date_serial, count: period_count, unit: period_unit};
		end
		for (int i = 2; i <= PIPE_DEPTH; i++) begin
			if (en[i]) begin
				ctx_s[i] <= ctx_s[i-1];
			end
		end
	end

	cda_to_civil u_to_civil (
		.clk      (clk),
		.en       (en),
		.date_s1  (ctx_s[1].date),
		.year_s6  (year_s6),
		.month_s6 (month_s6),
		.day_s6   (day_s6)
	);

	cda_shift u_shift (
		.clk      (clk),
		.en       (en),
		.ctx_s6   (ctx_s[6]),
		.unit_s7  (ctx_s[7].unit),
		.year_s6  (year_s6),
		.month_s6 (month_s6),
		.day_s6   (day_s6),
		.year_s8  (year_s8),
		.month_s8 (month_s8),
		.day_s8   (day_s8)
	);

	cda_to_serial u_to_serial (
		.clk      (clk),
		.en       (en),
		.year_s8  (year_s8),
		.month_s8 (month_s8),
		.day_s8   (day_s8),
		.base_s10 (base_s10),
		.doy_s10  (doy_s10)
	);

	// stage 10: day/week add, back to serial, unit and range check
	always_comb begin
		cnt22 = {{11{ctx_s[PIPE_DEPTH].count[10]}}, ctx_s[PIPE_DEPTH].count};
		step  = (ctx_s[PIPE_DEPTH].unit == UNIT_WEEKS) ? ((cnt22 << 3) - cnt22) : cnt22;
		res_d = $signed(22'(ctx_s[PIPE_DEPTH].date) + step);
		res_c = $signed(22'(base_s10) + 22'(doy_s10) - 22'(EPOCH_OFS));
		res   = ((ctx_s[PIPE_DEPTH].unit == UNIT_DAYS)
			|| (ctx_s[PIPE_DEPTH].unit == UNIT_WEEKS)) ? res_d : res_c;
		if (ctx_s[PIPE_DEPTH].unit > UNIT_YEARS) begin
			status_nx = ST_UNSUP;
			result_nx = ctx_s[PIPE_DEPTH].date;
		end else if ((res < $signed(22'(SERIAL_MIN))) || (res > $signed(22'(SERIAL_MAX)))) begin
			status_nx = ST_RANGE;
			result_nx = ctx_s[PIPE_DEPTH].date;
		end else begin
			status_nx = ST_OK;
			result_nx = res[16:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[PIPE_DEPTH+1]) begin
			result_q <= result_nx;
			status_q <= status_nx;
		end
	end

`ifndef SYNTHESIS
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (vld_s == '1) && result_valid_q && result_stall)
		else $error("input stalled while a pipeline stage is free");

	a_ok_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && (status_q == ST_OK))
		|-> ((result_q >= SERIAL_MIN) && (result_q <= SERIAL_MAX)))
		else $error("ok status with result outside the serial range");

	a_empty_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall && (vld_s == '0) && !result_valid_q)
		|=> ##(PIPE_DEPTH) result_valid_q)
		else $error("item through empty pipeline did not reach result register");
`endif

endmodule

[tb/calendar_date_add_period_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// calendar_date_add_period_tb: self-checking bench for the date shifter
// A queue of items (directed corner dates, then random shifts) feeds a
// clocked driver; a clocked monitor checks each result against a calendar
// predictor run at input acceptance. Both sides idle at random per phase,
// and the receiver holds off once long enough to back the pipeline up.
// ----------------------------------------------------------------------------
module calendar_date_add_period_tb;
	import cda_pkg::*;

	localparam int QUIET_LIMIT = 1000;
	localparam int HOLD_CYCLES = 80;
	localparam int DRAIN_CYCLES = 20;
	localparam int PHASE_ITEMS = 450;
	localparam longint MONTHS_PER_YEAR = 12;
	localparam longint DAYS_PER_WEEK = 7;
	localparam longint FEB_LEAP = 29;
	localparam longint FEB_PLAIN = 28;
	localparam longint FIRST_SERIAL = SERIAL_MIN;
	localparam longint LAST_SERIAL = SERIAL_MAX;

	typedef struct packed {
		logic [16:0] serial;
		status_t     st;
	} shift_out_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               item_valid = 1'b0;
	logic               item_stall;
	logic [16:0]        date_serial = '0;
	logic signed [10:0] period_count = '0;
	unit_t              period_unit = UNIT_DAYS;
	logic               result_valid;
	logic               result_stall = 1'b0;
	logic [16:0]        result_serial;
	status_t            status;

	item_ctx_t  pending_items[$];
	shift_out_t expected_shifts[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int results_seen = 0;
	int mismatch_cnt = 0;
	int quiet_cycles = 0;

	calendar_date_add_period u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.date_serial   (date_serial),
		.period_count  (period_count),
		.period_unit   (period_unit),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.result_serial (result_serial),
		.status        (status)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ---------------- calendar predictor ----------------

	function automatic bit is_leap(longint y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic longint month_len(longint y, longint m);
		case (m)
			2: return is_leap(y) ? FEB_LEAP : FEB_PLAIN;
			4, 6, 9, 11: return 30;
			default: return 31;
		endcase
	endfunction

	// days since 1 Jan 1970, valid for year >= 1
	function automatic longint civil_days(longint y, longint m, longint d);
		longint yy, era, yoe, mp, doy, doe;
		yy = (m <= 2) ? y - 1 : y;
		era = yy / 400;
		yoe = yy - era * 400;
		mp = (m > 2) ? m - 3 : m + 9;
		doy = (153 * mp + 2) / 5 + d - 1;
		doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
		return era * 146097 + doe - 719468;
	endfunction

	function automatic longint serial_of(longint y, longint m, longint d);
		return civil_days(y, m, d) - civil_days(1899, 12, 30);
	endfunction

	function automatic void civil_of(input longint s, output longint y, output longint m,
			output longint d);
		longint z, era, doe, yoe, doy, mp;
		z = s + civil_days(1899, 12, 30) + 719468;
		era = z / 146097;
		doe = z - era * 146097;
		yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
		doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
		mp = (5 * doy + 2) / 153;
		m = (mp < 10) ? mp + 3 : mp - 9;
		d = doy - (153 * mp + 2) / 5 + 1;
		y = yoe + era * 400 + ((m <= 2) ? 1 : 0);
	endfunction

	function automatic shift_out_t shift_date(item_ctx_t it);
		longint s, n, r, y, m, d, tot, lim;
		shift_out_t o;
		s = it.date;
		n = it.count;
		r = s;
		o.st = ST_OK;
		case (it.unit)
			UNIT_DAYS: r = s + n;
			UNIT_WEEKS: r = s + DAYS_PER_WEEK * n;
			UNIT_MONTHS: begin
				civil_of(s, y, m, d);
				tot = y * MONTHS_PER_YEAR + (m - 1) + n;
				y = tot / MONTHS_PER_YEAR;
				m = tot % MONTHS_PER_YEAR + 1;
				lim = month_len(y, m);
				if (d > lim)
					d = lim;
				r = serial_of(y, m, d);
			end
			UNIT_YEARS: begin
				civil_of(s, y, m, d);
				y = y + n;
				if (m == 2 && d == FEB_LEAP && !is_leap(y))
					d = FEB_PLAIN;
				r = serial_of(y, m, d);
			end
			default: o.st = ST_UNSUP;
		endcase
		if (o.st == ST_OK && (r < FIRST_SERIAL || r > LAST_SERIAL)) begin
			o.st = ST_RANGE;
			r = s;
		end
		o.serial = r[16:0];
		return o;
	endfunction

	// ---------------- stimulus ----------------

	task automatic add_item(input longint d, input int c, input unit_t u);
		item_ctx_t it;
		it.date = d[16:0];
		it.count = c[10:0];
		it.unit = u;
		pending_items.push_back(it);
	endtask

	function automatic item_ctx_t random_item();
		item_ctx_t it;
		int pick, c;
		longint y, m;
		pick = $urandom_range(99);
		it.unit = (pick < 88) ? unit_t'($urandom_range(3)) : unit_t'($urandom_range(7));
		pick = $urandom_range(99);
		if (pick < 70) begin
			it.date = 17'($urandom_range(SERIAL_MAX, SERIAL_MIN));
		end else if (pick < 85) begin
			// month ends, 29 Feb among them
			y = $urandom_range(2199, 1900);
			m = $urandom_range(12, 1);
			it.date = 17'(serial_of(y, m, month_len(y, m)));
		end else if (pick < 95) begin
			it.date = $urandom_range(1) ? 17'($urandom_range(40)) :
				SERIAL_MAX - 17'($urandom_range(40));
		end else begin
			it.date = 17'($urandom());
		end
		pick = $urandom_range(99);
		if (pick < 35)
			c = int'($urandom_range(80)) - 40;
		else if (pick < 60)
			c = int'($urandom_range(600)) - 300;
		else if (pick < 90)
			c = int'($urandom_range(2047)) - 1024;
		else
			c = $urandom_range(1) ? -1024 + int'($urandom_range(2)) :
				1023 - int'($urandom_range(2));
		it.count = c[10:0];
		return it;
	endfunction

	task automatic wait_queue_empty();
		while (pending_items.size() != 0)
			@(negedge clk);
	endtask

	initial begin : stimulus
		int k;
		add_item(1, 0, UNIT_DAYS);
		add_item(1, -1, UNIT_DAYS);
		add_item(SERIAL_MAX, 1, UNIT_DAYS);
		add_item(60, 1, UNIT_DAYS);
		add_item(0, 1023, UNIT_DAYS);
		add_item(17'h1FFFF, -1024, UNIT_DAYS);
		add_item(SERIAL_MAX, -1024, UNIT_WEEKS);
		add_item(17'h1FFFF, -1024, UNIT_WEEKS);
		add_item(50000, 1023, UNIT_WEEKS);
		add_item(serial_of(2001, 1, 31), 1, UNIT_MONTHS);
		add_item(serial_of(2000, 1, 31), 1, UNIT_MONTHS);
		add_item(serial_of(2000, 3, 31), -1, UNIT_MONTHS);
		add_item(serial_of(2050, 10, 31), 1, UNIT_MONTHS);
		add_item(serial_of(2050, 12, 15), 1, UNIT_MONTHS);
		add_item(serial_of(2051, 1, 15), -1, UNIT_MONTHS);
		add_item(serial_of(2050, 1, 1), 1023, UNIT_MONTHS);
		add_item(0, 0, UNIT_MONTHS);
		add_item(serial_of(2000, 2, 29), 1, UNIT_YEARS);
		add_item(serial_of(2000, 2, 29), 4, UNIT_YEARS);
		add_item(serial_of(2000, 2, 29), 100, UNIT_YEARS);
		add_item(serial_of(1904, 2, 29), -4, UNIT_YEARS);
		add_item(serial_of(2100, 1, 1), 1023, UNIT_YEARS);
		add_item(17'h1FFFF, -1024, UNIT_YEARS);
		for (k = 1; k <= 4; k++)
			add_item(40000 + k, k, unit_t'(UNIT_YEARS + k));
		for (k = 0; k < PHASE_ITEMS; k++)
			pending_items.push_back(random_item());

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		wait_queue_empty();
		send_idle_pct = 73;
		for (k = 0; k < PHASE_ITEMS; k++)
			pending_items.push_back(random_item());
		wait_queue_empty();
		send_idle_pct = 0;
		recv_stall_pct = 73;
		for (k = 0; k < PHASE_ITEMS; k++)
			pending_items.push_back(random_item());
		wait_queue_empty();
		send_idle_pct = 12;
		recv_stall_pct = 12;
		for (k = 0; k < PHASE_ITEMS; k++)
			pending_items.push_back(random_item());

		while (pending_items.size() != 0 || item_valid || expected_shifts.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// ---------------- driver ----------------

	always @(posedge clk or negedge arst_n) begin : driver
		item_ctx_t nxt;
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && !item_stall)
				expected_shifts.push_back(shift_date({date_serial, period_count, period_unit}));
			if (!item_valid || !item_stall) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = pending_items.pop_front();
					date_serial <= nxt.date;
					period_count <= nxt.count;
					period_unit <= nxt.unit;
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------- monitor ----------------

	always @(posedge clk or negedge arst_n) begin : monitor
		shift_out_t want;
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_shifts.size() == 0) begin
					$error("result with no item pending: result_serial %0d status %0d",
						result_serial, status);
					mismatch_cnt++;
				end else begin
					want = expected_shifts.pop_front();
					if (result_serial !== want.serial) begin
						$error("result_serial: expected %0d, got %0d", want.serial,
							result_serial);
						mismatch_cnt++;
					end
					if (status !== want.st) begin
						$error("status: expected %0d, got %0d", want.st, status);
						mismatch_cnt++;
					end
				end
				results_seen++;
			end
			// one long hold-off early on so the pipeline fills and item_stall rises
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				result_stall <= 1'b1;
			end else if (!hold_done && results_seen >= 20) begin
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// ---------------- watchdog ----------------

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

endmodule
